FILE: rtl/core/dttd_pkg.sv
// Shared constants and types for the transition/transversion distance block.
package dttd_pkg;

   localparam int WORD_BITS  = 32;
   localparam int WORD_BASES = WORD_BITS / 2;
   localparam int COUNT_W    = 16;
   localparam int DIST_W     = 47;
   localparam int LANE_COUNT = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX         = '1;
   localparam logic [COUNT_W-1:0] TOTAL_BASES_RESET = 16'd32000;

   // XOR of two 2-bit bases
   localparam logic [1:0] DIFF_NONE       = 2'b00;
   localparam logic [1:0] DIFF_TRANSITION = 2'b10;

   typedef struct packed {
      logic [COUNT_W-1:0] n2;
      logic [COUNT_W-1:0] n1;
   } totals_type;

   typedef struct packed {
      logic signed [DIST_W-1:0] distance;
      logic [COUNT_W-1:0]       n2;
      logic [COUNT_W-1:0]       n1;
   } result_type;

endpackage

FILE: rtl/core/dna_transition_transversion_distance.sv
// Top level: transition/transversion counter with distance term over DNA word pairs.
//
// Requests arrive on req_: tdata holds two aligned 32-bit words of 16 bases each,
// and tlast marks the final word pair of a sequence pair. Every request is split over
// parallel lanes that classify their bases; a merging stage adds the lane counts into
// two saturating 16-bit totals. On a last request the totals go to a four-stage
// multiply pipeline that forms (N-2n1-n2)^2*(N-2n2), saturated to 47 bits signed,
// and the result appears on rsp_. Non-last requests produce no result.
// One request is taken per cycle while req_tready is high.
// The multiply pipeline is the only place that can hold the input: if rsp_tready
// stays low, results back up in the pipeline stages and req_tready drops once a
// last request cannot move on, while ordinary words keep flowing into the totals.
// N is written on csr_, which is always ready; it should only change while idle.
// Reset clears both totals, empties the pipeline and sets N to 32000.
module dna_transition_transversion_distance #(
   parameter int LANE_COUNT = dttd_pkg::LANE_COUNT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // word_a [31:0], word_b [63:32]
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // transitions [15:0], transversions [31:16],
                                    // distance_value [78:32], zero [79]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // total_bases
);

   localparam int BASES = dttd_pkg::WORD_BASES / LANE_COUNT;
   localparam int CNT_W = $clog2(BASES + 1);
   localparam int WB    = dttd_pkg::WORD_BITS;

   logic [dttd_pkg::COUNT_W-1:0] total_bases_ff;
   logic                         lv_ff;
   logic                         llast_ff;
   logic                         req_take;
   logic                         l_drain;
   logic                         step;
   logic                         dist_ready;
   logic [WB-1:0]                diff;
   logic [LANE_COUNT-1:0][CNT_W-1:0] lane_ts;
   logic [LANE_COUNT-1:0][CNT_W-1:0] lane_tv;
   dttd_pkg::totals_type         totals;
   dttd_pkg::result_type         result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_bases_ff <= dttd_pkg::TOTAL_BASES_RESET;
      end else if (csr_valid) begin
         total_bases_ff <= csr_data;
      end
   end

   assign diff       = req_tdata[WB-1:0] ^ req_tdata[2*WB-1:WB];
   assign l_drain    = !llast_ff || dist_ready;
   assign req_tready = !lv_ff || l_drain;
   assign req_take   = req_tvalid && req_tready;
   assign step       = lv_ff && l_drain;

   always_ff @(posedge clock) begin
      if (reset) begin
         lv_ff <= 1'b0;
      end else if (req_tready) begin
         lv_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         llast_ff <= req_tlast;
      end
   end

   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      dttd_lane #(
         .BASES (BASES)
      ) u_lane (
         .clock    (clock),
         .load     (req_take),
         .diff     (diff[2*BASES*g +: 2*BASES]),
         .ts_count (lane_ts[g]),
         .tv_count (lane_tv[g])
      );
   end

   dttd_merge #(
      .LANE_COUNT (LANE_COUNT)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .last    (llast_ff),
      .lane_ts (lane_ts),
      .lane_tv (lane_tv),
      .totals  (totals)
   );

   dttd_dist u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (lv_ff && llast_ff),
      .in_ready    (dist_ready),
      .in_totals   (totals),
      .total_bases (total_bases_ff),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_result  (result)
   );

   assign rsp_tdata = {1'b0, result.distance, result.n2, result.n1};

endmodule

FILE: rtl/core/dttd_lane.sv
// One classification lane: counts transitions and transversions in a slice of bases.
module dttd_lane #(
   parameter int BASES = 4,
   localparam int CNT_W = $clog2(BASES + 1)
) (
   input  logic               clock,
   input  logic               load,
   input  logic [2*BASES-1:0] diff,
   output logic [CNT_W-1:0]   ts_count,
   output logic [CNT_W-1:0]   tv_count
);

   logic [CNT_W-1:0] ts_ff, ts_in;
   logic [CNT_W-1:0] tv_ff, tv_in;

   always_comb begin
      ts_in = '0;
      tv_in = '0;
      for (int i = 0; i < BASES; i++) begin
         case (diff[2*i +: 2])
            dttd_pkg::DIFF_NONE: begin
            end
            dttd_pkg::DIFF_TRANSITION: begin
               ts_in = ts_in + CNT_W'(1);
            end
            default: begin
               tv_in = tv_in + CNT_W'(1);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ts_ff <= ts_in;
         tv_ff <= tv_in;
      end
   end

   assign ts_count = ts_ff;
   assign tv_count = tv_ff;

endmodule

FILE: rtl/core/dttd_merge.sv
// Merging stage: sums the lane counts into two saturating totals per sequence pair.
module dttd_merge #(
   parameter int LANE_COUNT = dttd_pkg::LANE_COUNT,
   localparam int BASES = dttd_pkg::WORD_BASES / LANE_COUNT,
   localparam int CNT_W = $clog2(BASES + 1),
   localparam int SUM_W = $clog2(dttd_pkg::WORD_BASES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                last,
   input  logic [LANE_COUNT-1:0][CNT_W-1:0]    lane_ts,
   input  logic [LANE_COUNT-1:0][CNT_W-1:0]    lane_tv,
   output dttd_pkg::totals_type                totals
);

   localparam int CW = dttd_pkg::COUNT_W;

   logic [CW-1:0]    n1_ff, n1_in;
   logic [CW-1:0]    n2_ff, n2_in;
   logic [SUM_W-1:0] ts_sum;
   logic [SUM_W-1:0] tv_sum;
   logic [CW:0]      n1_raw;
   logic [CW:0]      n2_raw;
   logic [CW-1:0]    n1_sat;
   logic [CW-1:0]    n2_sat;

   always_comb begin
      ts_sum = '0;
      tv_sum = '0;
      for (int l = 0; l < LANE_COUNT; l++) begin
         ts_sum = ts_sum + SUM_W'(lane_ts[l]);
         tv_sum = tv_sum + SUM_W'(lane_tv[l]);
      end
      n1_raw = {1'b0, n1_ff} + (CW+1)'(ts_sum);
      n2_raw = {1'b0, n2_ff} + (CW+1)'(tv_sum);
      n1_sat = n1_raw[CW] ? dttd_pkg::COUNT_MAX : n1_raw[CW-1:0];
      n2_sat = n2_raw[CW] ? dttd_pkg::COUNT_MAX : n2_raw[CW-1:0];

      n1_in = n1_ff;
      n2_in = n2_ff;
      if (step) begin
         // The last word closes the sequence pair and starts the next one from zero.
         n1_in = last ? '0 : n1_sat;
         n2_in = last ? '0 : n2_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_ff <= '0;
         n2_ff <= '0;
      end else begin
         n1_ff <= n1_in;
         n2_ff <= n2_in;
      end
   end

   assign totals.n1 = n1_sat;
   assign totals.n2 = n2_sat;

endmodule

FILE: rtl/core/dttd_dist.sv
// Four-stage pipeline for the distance term (N-2n1-n2)^2 * (N-2n2) with saturation.
module dttd_dist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  dttd_pkg::totals_type        in_totals,
   input  logic [dttd_pkg::COUNT_W-1:0] total_bases,
   output logic                        out_valid,
   input  logic                        out_ready,
   output dttd_pkg::result_type        out_result
);

   localparam int CW     = dttd_pkg::COUNT_W;
   localparam int DW     = dttd_pkg::DIST_W;
   localparam int A_W    = CW + 3;
   localparam int B_W    = CW + 2;
   localparam int SQ_W   = 2 * (CW + 2);
   localparam int HALF_W = SQ_W / 2;
   localparam int P_W    = HALF_W + 1 + B_W;
   localparam int D_W    = SQ_W + B_W + 1;

   localparam logic signed [DW-1:0] DIST_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DIST_MIN = {1'b1, {(DW-1){1'b0}}};

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;

   dttd_pkg::totals_type t1_ff, t2_ff, t3_ff;
   logic signed [A_W-1:0]    a_ff;
   logic signed [B_W-1:0]    b1_ff, b2_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic signed [P_W-1:0]    p_hi_ff, p_lo_ff;
   dttd_pkg::result_type     res_ff, res_in;

   logic signed [A_W-1:0]    a_in;
   logic signed [B_W-1:0]    b_in;
   logic signed [2*A_W-1:0]  sq_full;
   logic signed [P_W-1:0]    p_hi_in, p_lo_in;
   logic signed [D_W-1:0]    d_sum;

   assign r4       = !v4_ff || out_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   assign a_in = signed'(A_W'(total_bases)) - signed'(A_W'({in_totals.n1, 1'b0}))
                 - signed'(A_W'(in_totals.n2));
   assign b_in = signed'(B_W'(total_bases)) - signed'(B_W'({in_totals.n2, 1'b0}));

   assign sq_full = a_ff * a_ff;

   // The square is split in halves so each product stays near 18 by 18 bits.
   assign p_hi_in = signed'({1'b0, sq_ff[SQ_W-1:HALF_W]}) * b2_ff;
   assign p_lo_in = signed'({1'b0, sq_ff[HALF_W-1:0]}) * b2_ff;

   always_comb begin
      d_sum = (D_W'(p_hi_ff) <<< HALF_W) + D_W'(p_lo_ff);
      res_in.n1 = t3_ff.n1;
      res_in.n2 = t3_ff.n2;
      if (d_sum > D_W'(DIST_MAX)) begin
         res_in.distance = DIST_MAX;
      end else if (d_sum < D_W'(DIST_MIN)) begin
         res_in.distance = DIST_MIN;
      end else begin
         res_in.distance = d_sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         t1_ff <= in_totals;
         a_ff  <= a_in;
         b1_ff <= b_in;
      end
      if (r2) begin
         t2_ff <= t1_ff;
         sq_ff <= sq_full[SQ_W-1:0];
         b2_ff <= b1_ff;
      end
      if (r3) begin
         t3_ff   <= t2_ff;
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
      end
      if (r4) begin
         res_ff <= res_in;
      end
   end

   assign out_valid  = v4_ff;
   assign out_result = res_ff;

endmodule

FILE: rtl/core/dttd_checker.sv
// Port-level checks for the distance block, bound to the top level.
module dttd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   // A result waiting on the receiver keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Reset empties the result pipeline.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // With no differences at all the distance is N cubed, saturated at the limit, never negative.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:0] == 32'd0 |-> !rsp_tdata[78])
      else $error("negative distance with zero counts");

   // The pad bit above the distance stays clear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[79])
      else $error("response pad bit set");

   // A request, with or without a last mark, cannot be blocked by the result pipeline
   // when nothing is pending in front of it.
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && !$past(req_tvalid) && !$past(rsp_tvalid) && !rsp_tvalid
      |-> req_tready)
      else $error("request side stalled with an empty pipeline");

endmodule

bind dna_transition_transversion_distance dttd_checker u_dttd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: dv/dna_ttd_checker.sv
// Checker that predicts and compares the results of the transition/transversion distance block.
module dna_ttd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          failures,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CW      = dttd_pkg::COUNT_W;
   localparam longint DIST_HI = (longint'(1) << (dttd_pkg::DIST_W - 1)) - 1;
   localparam longint DIST_LO = -(longint'(1) << (dttd_pkg::DIST_W - 1));

   logic [CW-1:0]        base_total;
   logic [CW-1:0]        ts_total;
   logic [CW-1:0]        tv_total;
   dttd_pkg::result_type expected_results[$];

   function automatic logic [CW-1:0] sat_count(logic [CW-1:0] acc, int inc);
      int sum;
      sum = int'(acc) + inc;
      return (sum > int'(dttd_pkg::COUNT_MAX)) ? dttd_pkg::COUNT_MAX : sum[CW-1:0];
   endfunction

   function automatic logic signed [dttd_pkg::DIST_W-1:0] kimura_term(logic [CW-1:0] n,
                                                                     logic [CW-1:0] n1,
                                                                     logic [CW-1:0] n2);
      longint lhs;
      longint rhs;
      longint prod;
      lhs  = longint'(n) - 2 * longint'(n1) - longint'(n2);
      rhs  = longint'(n) - 2 * longint'(n2);
      prod = lhs * lhs * rhs;
      if (prod > DIST_HI) prod = DIST_HI;
      if (prod < DIST_LO) prod = DIST_LO;
      return prod[dttd_pkg::DIST_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      logic [dttd_pkg::WORD_BITS-1:0] word_a;
      logic [dttd_pkg::WORD_BITS-1:0] word_b;
      logic [1:0]                     pair;
      int                             ts_count;
      int                             tv_count;
      dttd_pkg::result_type           want;
      dttd_pkg::result_type           got;
      if (reset) begin
         base_total = dttd_pkg::TOTAL_BASES_RESET;
         ts_total   = '0;
         tv_total   = '0;
         expected_results.delete();
         failures    <= 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready)
            base_total = csr_data;

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[78:0];
            if (expected_results.size() == 0) begin
               if (failures < 10)
                  $display("%0t: result with no request pending: n1=%0d n2=%0d dist=%0d",
                           $realtime, got.n1, got.n2, got.distance);
               failures <= failures + 1;
            end else begin
               want = expected_results.pop_front();
               if (got !== want || rsp_tdata[79] !== 1'b0) begin
                  if (failures < 10)
                     $display({"%0t: mismatch: expected n1=%0d n2=%0d dist=%0d, ",
                               "got n1=%0d n2=%0d dist=%0d pad=%b"},
                              $realtime, want.n1, want.n2, want.distance,
                              got.n1, got.n2, got.distance, rsp_tdata[79]);
                  failures <= failures + 1;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            word_a   = req_tdata[31:0];
            word_b   = req_tdata[63:32];
            ts_count = 0;
            tv_count = 0;
            for (int i = 0; i < dttd_pkg::WORD_BASES; i++) begin
               pair = word_a[2*i +: 2] ^ word_b[2*i +: 2];
               if (pair == dttd_pkg::DIFF_TRANSITION)
                  ts_count++;
               else if (pair != dttd_pkg::DIFF_NONE)
                  tv_count++;
            end
            ts_total = sat_count(ts_total, ts_count);
            tv_total = sat_count(tv_total, tv_count);
            if (req_tlast) begin
               want.n1       = ts_total;
               want.n2       = tv_total;
               want.distance = kimura_term(base_total, ts_total, tv_total);
               expected_results.push_back(want);
               ts_total = '0;
               tv_total = '0;
            end
         end
         outstanding <= expected_results.size();
      end
   end

endmodule

FILE: dv/dna_transition_transversion_distance_tb.sv
// Testbench top: drives requests and settings into the distance block and reports the verdict.
module dna_transition_transversion_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // word_a [31:0], word_b [63:32]
   logic        req_tlast = 1'b0; // last_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // transitions [15:0], transversions [31:16],
                                  // distance_value [78:32], zero [79]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;    // total_bases

   int failures;
   int outstanding;
   int idle_pct = 0;
   int stall_pct = 0;

   dna_transition_transversion_distance u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   dna_ttd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic push_word(input logic [31:0] word_a, input logic [31:0] word_b,
                            input logic last);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {word_b, word_a};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_results;
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // The block may still be adding up a word after the last result, so give it time.
   task automatic write_total_bases(input logic [15:0] value);
      wait_results();
      repeat (10) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A fixed difference makes every word of the sequence classify the same way.
   task automatic send_sequence(input int words, input bit use_fixed,
                                input logic [31:0] fixed_diff);
      logic [31:0] word_a;
      logic [31:0] word_b;
      for (int i = 0; i < words; i++) begin
         word_a = $urandom;
         if (use_fixed) begin
            word_b = word_a ^ fixed_diff;
         end else begin
            case ($urandom_range(4))
               0:       word_b = word_a;
               1:       word_b = word_a ^ ($urandom & 32'hAAAA_AAAA);
               2:       word_b = ~word_a;
               default: word_b = $urandom;
            endcase
         end
         push_word(word_a, word_b, i == words - 1);
      end
   endtask

   initial begin
      int sent;
      int len;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Short directed requests under the reset value of the base count.
      push_word(32'h0000_0000, 32'h0000_0000, 1'b1);
      push_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      push_word(32'h0000_0000, 32'hAAAA_AAAA, 1'b0);
      push_word(32'h0000_0000, 32'h5555_5555, 1'b0);
      push_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
      push_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
      push_word(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
      push_word(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      push_word(32'h0123_4567, 32'h89AB_CDEF, 1'b1);
      push_word(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1);
      push_word(32'h1B1B_1B1B, 32'hE4E4_E4E4, 1'b1);

      // A base count above the usual range drives the distance past its positive limit.
      write_total_bases(16'hFFFF);
      send_sequence(1, 1'b1, 32'h0000_0000);
      send_sequence(3, 1'b1, 32'hAAAA_AAAA);
      // With N of zero the second factor turns negative.
      write_total_bases(16'd0);
      send_sequence(3, 1'b1, 32'hFFFF_FFFF);
      send_sequence(2, 1'b1, 32'h5555_5555);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_total_bases(16'($urandom_range(32768)));
            1: write_total_bases(16'd32768);
            2: write_total_bases(16'd0);
            default: write_total_bases(16'd1);
         endcase
         idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 20 : 0;
         stall_pct = (phase == 2) ? 64 : (phase == 3) ? 20 : 0;
         sent = 0;
         while (sent < 385) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 20) : $urandom_range(8, 1);
            send_sequence(len, 1'b0, 32'h0);
            sent += len;
            if (phase == 2 && sent >= 190 && sent - len < 190)
               wait_results();
         end
      end

      wait_results();
      repeat (10) @(negedge clock);
      if (failures == 0 && outstanding == 0)
         $display("dna_transition_transversion_distance_tb: PASS");
      else
         $display("dna_transition_transversion_distance_tb: FAIL");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("dna_transition_transversion_distance_tb: FAIL");
      $finish;
   end

endmodule
